// File: rtl/core/float_complex_multiply_add_top_defines.svh
// Assertion helpers for the complex multiply-add block.
// They expect a signal named clk, and all but FCMA_AST_NXT_ALL also rst_n, where they are used.
`ifndef FLOAT_COMPLEX_MULTIPLY_ADD_TOP_DEFINES_SVH
`define FLOAT_COMPLEX_MULTIPLY_ADD_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define FCMA_AST_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

// next-cycle implication, off during reset
`define FCMA_AST_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

// next-cycle implication, always checked
`define FCMA_AST_NXT_ALL(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (expr)) else $error(msg);

`endif

// File: rtl/core/fcma_pkg.sv
// ----------------------------------------------------------------------------
// fcma_pkg
// Types, constants and the shared round/pack function of the complex
// single-precision multiply-add pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcma_pkg;

  typedef struct packed {
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic        in_last;
  } in_t;

  typedef struct packed {
    logic [31:0] sum_re;
    logic [31:0] sum_im;
    logic        out_last;
  } out_t;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [7:0]  EXP_MAX  = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] REG_COMPLEX_MODE = 2'd0;
  localparam logic [1:0] REG_USE_CONSTANT = 2'd1;
  localparam logic [1:0] REG_CONST_RE     = 2'd2;
  localparam logic [1:0] REG_CONST_IM     = 2'd3;

  localparam int MUL_STAGES = 2;
  localparam int ADD_STAGES = 5;
  localparam int NSTG       = 1 + MUL_STAGES + 2 * ADD_STAGES;

  // t: unbiased exponent of the leading one, m: 24-bit significand,
  // g/st: guard and sticky. Flushes tiny values, rounds to nearest even.
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [9:0] t,
                                             input logic [23:0] m,
                                             input logic g,
                                             input logic st);
    logic [24:0]        mr;
    logic signed [9:0]  te;
    logic [31:0]        res;
    mr  = {1'b0, m} + {24'd0, g & (st | m[0])};
    te  = t;
    res = '0;
    if (t < -10'sd126) begin
      res = {sign, 31'd0};
    end else begin
      if (mr[24]) begin
        mr = mr >> 1;
        te = t + 10'sd1;
      end
      if (te > 10'sd127) begin
        res = {sign, EXP_MAX, 23'd0};
      end else begin
        res = {sign, 8'(te + 10'sd127), mr[22:0]};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fcma_fmul.sv
// ----------------------------------------------------------------------------
// fcma_fmul
// Two-stage single-precision multiplier: significand product, then
// normalize, round and pack. Each stage has its own advance enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcma_fmul (
  input  wire logic        clk,
  input  wire logic [1:0]  en,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  output logic      [31:0] z
);
  import fcma_pkg::*;

  logic        spc_nxt, spc_r;
  logic [31:0] spcv_nxt, spcv_r;
  logic        sgn_nxt, sgn_r;
  logic [8:0]  esum_nxt, esum_r;
  logic [47:0] prod_nxt, prod_r;
  logic [31:0] z_nxt, z_r;

  logic xn, yn, xi, yi, xz, yz;

  always_comb begin
    xn = (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
    yn = (y[30:23] == EXP_MAX) && (y[22:0] != 23'd0);
    xi = (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
    yi = (y[30:23] == EXP_MAX) && (y[22:0] == 23'd0);
    xz = (x[30:23] == 8'd0);
    yz = (y[30:23] == 8'd0);
    sgn_nxt  = x[31] ^ y[31];
    spc_nxt  = 1'b1;
    spcv_nxt = QNAN;
    if (xn || yn || (xi && yz) || (yi && xz)) begin
      spcv_nxt = QNAN;
    end else if (xi || yi) begin
      spcv_nxt = {sgn_nxt, EXP_MAX, 23'd0};
    end else if (xz || yz) begin
      spcv_nxt = {sgn_nxt, 31'd0};
    end else begin
      spc_nxt = 1'b0;
    end
    esum_nxt = {1'b0, x[30:23]} + {1'b0, y[30:23]};
    prod_nxt = {1'b1, x[22:0]} * {1'b1, y[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      spc_r  <= spc_nxt;
      spcv_r <= spcv_nxt;
      sgn_r  <= sgn_nxt;
      esum_r <= esum_nxt;
      prod_r <= prod_nxt;
    end
  end

  logic [47:0]       norm;
  logic signed [9:0] t;

  always_comb begin
    norm = prod_r[47] ? prod_r : (prod_r << 1);
    t    = $signed({1'b0, esum_r}) - 10'sd254 + $signed({9'd0, prod_r[47]});
    z_nxt = spc_r ? spcv_r
                  : round_pack(sgn_r, t, norm[47:24], norm[23], |norm[22:0]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z_r <= z_nxt;
    end
  end

  assign z = z_r;

endmodule

`default_nettype wire

// File: rtl/core/fcma_fadd.sv
// ----------------------------------------------------------------------------
// fcma_fadd
// Five-stage single-precision adder: classify/swap, align, add,
// leading-one search, normalize/round/pack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcma_fadd (
  input  wire logic        clk,
  input  wire logic [4:0]  en,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  output logic      [31:0] z
);
  import fcma_pkg::*;

  // stage 1: specials and operand order
  logic        spc_nxt, sub_nxt, sgn_nxt;
  logic [31:0] spcv_nxt;
  logic [7:0]  e_nxt, d_nxt;
  logic [23:0] bm_nxt, sm_nxt;
  logic        s1_spc_r, s1_sub_r, s1_sgn_r;
  logic [31:0] s1_spcv_r;
  logic [7:0]  s1_e_r, s1_d_r;
  logic [23:0] s1_bm_r, s1_sm_r;

  logic xn, yn, xi, yi, xz, yz, swp;

  always_comb begin
    xn = (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
    yn = (y[30:23] == EXP_MAX) && (y[22:0] != 23'd0);
    xi = (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
    yi = (y[30:23] == EXP_MAX) && (y[22:0] == 23'd0);
    xz = (x[30:23] == 8'd0);
    yz = (y[30:23] == 8'd0);
    spc_nxt  = 1'b1;
    spcv_nxt = QNAN;
    if (xn || yn) begin
      spcv_nxt = QNAN;
    end else if (xi && yi) begin
      spcv_nxt = (x[31] == y[31]) ? x : QNAN;
    end else if (xi) begin
      spcv_nxt = x;
    end else if (yi) begin
      spcv_nxt = y;
    end else if (xz && yz) begin
      spcv_nxt = {x[31] & y[31], 31'd0};
    end else if (xz) begin
      spcv_nxt = y;
    end else if (yz) begin
      spcv_nxt = x;
    end else begin
      spc_nxt = 1'b0;
    end
    swp     = x[30:0] < y[30:0];
    sgn_nxt = swp ? y[31] : x[31];
    sub_nxt = x[31] ^ y[31];
    e_nxt   = swp ? y[30:23] : x[30:23];
    bm_nxt  = swp ? {1'b1, y[22:0]} : {1'b1, x[22:0]};
    sm_nxt  = swp ? {1'b1, x[22:0]} : {1'b1, y[22:0]};
    d_nxt   = swp ? (y[30:23] - x[30:23]) : (x[30:23] - y[30:23]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_spc_r  <= spc_nxt;
      s1_spcv_r <= spcv_nxt;
      s1_sub_r  <= sub_nxt;
      s1_sgn_r  <= sgn_nxt;
      s1_e_r    <= e_nxt;
      s1_d_r    <= d_nxt;
      s1_bm_r   <= bm_nxt;
      s1_sm_r   <= sm_nxt;
    end
  end

  // stage 2: align smaller operand, 3 extra bits with sticky
  logic [26:0] ext, mask, al_nxt;
  logic        s2_spc_r, s2_sub_r, s2_sgn_r;
  logic [31:0] s2_spcv_r;
  logic [7:0]  s2_e_r;
  logic [23:0] s2_bm_r;
  logic [26:0] s2_al_r;

  always_comb begin
    ext  = {s1_sm_r, 3'd0};
    mask = (27'd1 << s1_d_r[4:0]) - 27'd1;
    if (s1_d_r >= 8'd27) begin
      al_nxt = 27'd1;
    end else begin
      al_nxt = (ext >> s1_d_r[4:0]) | {26'd0, |(ext & mask)};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_spc_r  <= s1_spc_r;
      s2_spcv_r <= s1_spcv_r;
      s2_sub_r  <= s1_sub_r;
      s2_sgn_r  <= s1_sgn_r;
      s2_e_r    <= s1_e_r;
      s2_bm_r   <= s1_bm_r;
      s2_al_r   <= al_nxt;
    end
  end

  // stage 3: add or subtract magnitudes
  logic [27:0] r_nxt;
  logic        s3_spc_r, s3_sgn_r, s3_zero_r;
  logic [31:0] s3_spcv_r;
  logic [7:0]  s3_e_r;
  logic [27:0] s3_r_r;

  always_comb begin
    if (s2_sub_r) begin
      r_nxt = {1'b0, s2_bm_r, 3'd0} - {1'b0, s2_al_r};
    end else begin
      r_nxt = {1'b0, s2_bm_r, 3'd0} + {1'b0, s2_al_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_spc_r  <= s2_spc_r;
      s3_spcv_r <= s2_spcv_r;
      s3_sgn_r  <= s2_sgn_r;
      s3_e_r    <= s2_e_r;
      s3_r_r    <= r_nxt;
      s3_zero_r <= (r_nxt == 28'd0);
    end
  end

  // stage 4: leading-one position
  logic [4:0]  lz_nxt;
  logic        s4_spc_r, s4_sgn_r, s4_zero_r;
  logic [31:0] s4_spcv_r;
  logic [7:0]  s4_e_r;
  logic [27:0] s4_r_r;
  logic [4:0]  s4_lz_r;

  always_comb begin
    lz_nxt = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (s3_r_r[i]) begin
        lz_nxt = 5'(27 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_spc_r  <= s3_spc_r;
      s4_spcv_r <= s3_spcv_r;
      s4_sgn_r  <= s3_sgn_r;
      s4_zero_r <= s3_zero_r;
      s4_e_r    <= s3_e_r;
      s4_r_r    <= s3_r_r;
      s4_lz_r   <= lz_nxt;
    end
  end

  // stage 5: normalize, round, pack
  logic [27:0]       n;
  logic signed [9:0] t;
  logic [31:0]       z_nxt, z_r;

  always_comb begin
    n = s4_r_r << s4_lz_r;
    t = $signed({2'd0, s4_e_r}) - 10'sd126 - $signed({5'd0, s4_lz_r});
    if (s4_spc_r) begin
      z_nxt = s4_spcv_r;
    end else if (s4_zero_r) begin
      z_nxt = 32'd0;   // exact cancellation gives +0
    end else begin
      z_nxt = round_pack(s4_sgn_r, t, n[27:4], n[3], |n[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      z_r <= z_nxt;
    end
  end

  assign z = z_r;

endmodule

`default_nettype wire

// File: rtl/core/float_complex_multiply_add_top.sv
// ----------------------------------------------------------------------------
// float_complex_multiply_add_top
// Streaming single-precision (complex) multiply-add: c + a*b, each
// product and sum rounded separately.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  input   | in_valid, in_stall, in_data    | taken when in_valid && !in_stall
//  result  | out_valid, out_stall, out_data | taken when out_valid && !out_stall
//  config  | cfg_we, cfg_index, cfg_wdata   | written when cfg_we
//
//  One transaction per cycle while out_stall is low. Stages: input register,
//  2-stage multipliers, two 5-stage adders in series.
//  Each stage advances when it is empty or the stage after it advances,
//  so bubbles close up under an output stall.
//  rst_n clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module float_complex_multiply_add_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire fcma_pkg::in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output fcma_pkg::out_t    out_data,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import fcma_pkg::*;

  localparam int M0 = 1;                   // first multiplier stage
  localparam int A1 = 1 + MUL_STAGES;      // first adder stage
  localparam int A2 = A1 + ADD_STAGES;     // second adder stage

  // configuration
  logic        complex_mode_r, use_constant_r;
  logic [31:0] const_re_r, const_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_mode_r <= 1'b0;
      use_constant_r <= 1'b0;
      const_re_r     <= '0;
      const_im_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPLEX_MODE: complex_mode_r <= cfg_wdata[0];
        REG_USE_CONSTANT: use_constant_r <= cfg_wdata[0];
        REG_CONST_RE:     const_re_r     <= cfg_wdata;
        REG_CONST_IM:     const_im_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [NSTG-1:0] vld_r, en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];

  // input register with constant factor substitution
  in_t s0_nxt, s0_r;

  always_comb begin
    s0_nxt = in_data;
    if (use_constant_r) begin
      s0_nxt.b_re = const_re_r;
      s0_nxt.b_im = const_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
  end

  // four products
  logic [31:0] p_rr, p_ii, p_ri, p_ir;

  fcma_fmul u_mul_rr (.clk(clk), .en(en[M0 +: MUL_STAGES]),
                      .x(s0_r.a_re), .y(s0_r.b_re), .z(p_rr));
  fcma_fmul u_mul_ii (.clk(clk), .en(en[M0 +: MUL_STAGES]),
                      .x(s0_r.a_im), .y(s0_r.b_im), .z(p_ii));
  fcma_fmul u_mul_ri (.clk(clk), .en(en[M0 +: MUL_STAGES]),
                      .x(s0_r.a_re), .y(s0_r.b_im), .z(p_ri));
  fcma_fmul u_mul_ir (.clk(clk), .en(en[M0 +: MUL_STAGES]),
                      .x(s0_r.a_im), .y(s0_r.b_re), .z(p_ir));

  // addends ride alongside the multipliers
  logic [63:0] cd_r [MUL_STAGES];

  always_ff @(posedge clk) begin
    if (en[M0]) begin
      cd_r[0] <= {s0_r.c_re, s0_r.c_im};
    end
    for (int k = 1; k < MUL_STAGES; k++) begin
      if (en[M0+k]) begin
        cd_r[k] <= cd_r[k-1];
      end
    end
  end

  // first sums
  logic [31:0] r1, i1;

  fcma_fadd u_add_re1 (.clk(clk), .en(en[A1 +: ADD_STAGES]),
                       .x(cd_r[MUL_STAGES-1][63:32]), .y(p_rr), .z(r1));
  fcma_fadd u_add_im1 (.clk(clk), .en(en[A1 +: ADD_STAGES]),
                       .x(cd_r[MUL_STAGES-1][31:0]), .y(p_ri), .z(i1));

  // second products wait for the first sums; a_im*b_im enters negated
  logic [63:0] pd_r [ADD_STAGES];

  always_ff @(posedge clk) begin
    if (en[A1]) begin
      pd_r[0] <= {p_ii ^ SIGN_BIT, p_ir};
    end
    for (int k = 1; k < ADD_STAGES; k++) begin
      if (en[A1+k]) begin
        pd_r[k] <= pd_r[k-1];
      end
    end
  end

  logic [31:0] r2, i2;

  fcma_fadd u_add_re2 (.clk(clk), .en(en[A2 +: ADD_STAGES]),
                       .x(r1), .y(pd_r[ADD_STAGES-1][63:32]), .z(r2));
  fcma_fadd u_add_im2 (.clk(clk), .en(en[A2 +: ADD_STAGES]),
                       .x(i1), .y(pd_r[ADD_STAGES-1][31:0]), .z(i2));

  // real-mode result skips the second adder
  logic [31:0] r1d_r [ADD_STAGES];

  always_ff @(posedge clk) begin
    if (en[A2]) begin
      r1d_r[0] <= r1;
    end
    for (int k = 1; k < ADD_STAGES; k++) begin
      if (en[A2+k]) begin
        r1d_r[k] <= r1d_r[k-1];
      end
    end
  end

  // end-of-vector marker
  logic [NSTG-1:1] last_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      last_r[1] <= s0_r.in_last;
    end
    for (int k = 2; k < NSTG; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // configuration must only change with the pipeline empty; the block does not enforce it
  always_comb begin
    out_data.sum_re   = complex_mode_r ? r2 : r1d_r[ADD_STAGES-1];
    out_data.sum_im   = complex_mode_r ? i2 : 32'd0;
    out_data.out_last = last_r[NSTG-1];
  end

endmodule

`default_nettype wire

// File: rtl/core/fcma_checker.sv
// ----------------------------------------------------------------------------
// fcma_checker
// Port-level checks of the complex multiply-add block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "float_complex_multiply_add_top_defines.svh"

module fcma_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire fcma_pkg::out_t out_data
);
  import fcma_pkg::*;

  logic re_nan;

  assign re_nan = (out_data.sum_re[30:23] == EXP_MAX) && (out_data.sum_re[22:0] != 23'd0);

  `FCMA_AST_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `FCMA_AST_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `FCMA_AST_NXT_ALL(a_rst_empty, !rst_n, !out_valid, "result valid after reset")
  `FCMA_AST_IMP(a_flow, !out_valid || !out_stall, !in_stall, "input stalled with free output")
  `FCMA_AST_IMP(a_qnan, out_valid && re_nan, out_data.sum_re == QNAN, "NaN not default NaN")

endmodule

bind float_complex_multiply_add_top fcma_checker u_fcma_checker (.*);

`default_nettype wire

// File: sim/tb_float_complex_multiply_add_top.sv
// ----------------------------------------------------------------------------
// tb_float_complex_multiply_add_top
// Streams operand transactions through the complex multiply-add block under
// random valid/stall gaps and checks each result against a bit-exact
// single-precision predictor (flush-to-zero, round to nearest even).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_float_complex_multiply_add_top;
  import fcma_pkg::*;

  localparam logic [31:0] INF_POS  = 32'h7F80_0000;
  localparam logic [31:0] MAX_FIN  = 32'h7F7F_FFFF;
  localparam logic [31:0] MIN_NORM = 32'h0080_0000;
  localparam logic [31:0] ONE      = 32'h3F80_0000;
  localparam int          DRAIN    = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_COMPLEX_MODE;
  logic [31:0] cfg_wdata = '0;

  float_complex_multiply_add_top DUT (.*);

  always #1 clk = ~clk;

  // predictor copy of the configuration
  logic        mode_cplx = 1'b0;
  logic        mode_const = 1'b0;
  logic [31:0] k_re = '0;
  logic [31:0] k_im = '0;

  in_t  pending_q[$];
  out_t expected_q[$];
  int   errors = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;
  int   hold_cycles = 0;

  function automatic bit f_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction
  function automatic bit f_inf(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction
  function automatic bit f_zero(logic [31:0] x);
    return x[30:23] == 8'h00;
  endfunction

  // value = sig * 2^(e-62)
  function automatic logic [31:0] norm_round(logic s, int e, logic [63:0] sig);
    logic [63:0] m, rem;
    while (sig[63]) begin
      sig = (sig >> 1) | {63'd0, sig[0]};
      e++;
    end
    while (!sig[62]) begin
      sig = sig << 1;
      e--;
    end
    if (e < -126) return {s, 31'd0};
    m   = sig >> 39;
    rem = sig & ((64'd1 << 39) - 1);
    if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && m[0])) m++;
    if (m[24]) begin
      m = m >> 1;
      e++;
    end
    if (e > 127) return {s, INF_POS[30:0]};
    return {s, 8'(e + 127), m[22:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] x, logic [31:0] y);
    logic s;
    s = x[31] ^ y[31];
    if (f_nan(x) || f_nan(y)) return QNAN;
    if ((f_inf(x) && f_zero(y)) || (f_inf(y) && f_zero(x))) return QNAN;
    if (f_inf(x) || f_inf(y)) return {s, INF_POS[30:0]};
    if (f_zero(x) || f_zero(y)) return {s, 31'd0};
    return norm_round(s, int'(x[30:23]) + int'(y[30:23]) - 238,
                      64'({1'b1, x[22:0]}) * 64'({1'b1, y[22:0]}));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] x, logic [31:0] y);
    logic        sx, sy, ts;
    int          ex, ey, te, d;
    logic [63:0] ux, uy, tu;
    sx = x[31];
    sy = y[31];
    if (f_nan(x) || f_nan(y)) return QNAN;
    if (f_inf(x) && f_inf(y)) return (sx == sy) ? x : QNAN;
    if (f_inf(x)) return x;
    if (f_inf(y)) return y;
    if (f_zero(x) && f_zero(y)) return {sx & sy, 31'd0};
    if (f_zero(x)) return y;
    if (f_zero(y)) return x;
    ex = int'(x[30:23]) - 127;
    ey = int'(y[30:23]) - 127;
    ux = 64'({1'b1, x[22:0]}) << 39;
    uy = 64'({1'b1, y[22:0]}) << 39;
    if (ex < ey || (ex == ey && ux < uy)) begin
      ts = sx; te = ex; tu = ux;
      sx = sy; ex = ey; ux = uy;
      sy = ts; ey = te; uy = tu;
    end
    d = ex - ey;
    if (d >= 63) uy = 64'd1;
    else if (d > 0) uy = (uy >> d) | {63'd0, (uy & ((64'd1 << d) - 1)) != 0};
    if (sx == sy) return norm_round(sx, ex, ux + uy);
    if (ux == uy) return '0;
    return norm_round(sx, ex, ux - uy);
  endfunction

  function automatic out_t cmac_predict(in_t t);
    out_t        r;
    logic [31:0] br, bi;
    br = mode_const ? k_re : t.b_re;
    bi = mode_const ? k_im : t.b_im;
    r.sum_re = sp_add(t.c_re, sp_mul(t.a_re, br));
    r.sum_im = '0;
    if (mode_cplx) begin
      r.sum_re = sp_add(r.sum_re, sp_mul(t.a_im, bi) ^ SIGN_BIT);
      r.sum_im = sp_add(sp_add(t.c_im, sp_mul(t.a_re, bi)), sp_mul(t.a_im, br));
    end
    r.out_last = t.in_last;
    return r;
  endfunction

  // random float biased toward special exponents and near-equal magnitudes
  function automatic logic [31:0] rnd_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'($urandom_range(0, 3) + 8'hFC);
      3: v[30:23] = 8'($urandom_range(1, 4));
      4: v[22:0]  = '0;
      default: v[30:23] = 8'($urandom_range(100, 154));
    endcase
    return v;
  endfunction

  function automatic in_t rnd_item();
    in_t t;
    t.a_re = rnd_float();
    t.a_im = rnd_float();
    t.b_re = rnd_float();
    t.b_im = rnd_float();
    t.c_re = rnd_float();
    t.c_im = rnd_float();
    t.in_last = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) t.c_re = sp_mul(t.a_re, t.b_re) ^ SIGN_BIT;
    return t;
  endfunction

  // driver: the queue head is the transaction on the bus until it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(cmac_predict(in_data));
        void'(pending_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (pending_q.size() != 0 &&
                   (calm_in || $urandom_range(0, 99) >= 35)) begin
        in_valid <= 1'b1;
        in_data  <= pending_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          errors++;
        end else begin
          if (out_data.sum_re !== expected_q[0].sum_re) begin
            $error("sum_re expected %h actual %h", expected_q[0].sum_re, out_data.sum_re);
            errors++;
          end
          if (out_data.sum_im !== expected_q[0].sum_im) begin
            $error("sum_im expected %h actual %h", expected_q[0].sum_im, out_data.sum_im);
            errors++;
          end
          if (out_data.out_last !== expected_q[0].out_last) begin
            $error("out_last expected %b actual %b", expected_q[0].out_last,
                   out_data.out_last);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= !calm_out && $urandom_range(0, 99) < 35;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_COMPLEX_MODE: mode_cplx  = val[0];
      REG_USE_CONSTANT: mode_const = val[0];
      REG_CONST_RE:     k_re = val;
      REG_CONST_IM:     k_im = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) pending_q.push_back(rnd_item());
    wait_idle();
  endtask

  task automatic push_op(logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                         logic [31:0] bi, logic [31:0] cr, logic [31:0] ci);
    in_t t;
    t = '{ar, ai, br, bi, cr, ci, 1'b1};
    pending_q.push_back(t);
  endtask

  task automatic directed_set();
    push_op('0, '0, '0, '0, '0, '0);
    push_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(32'h0000_0001, ONE, 32'h807F_FFFF, ONE, ONE, SIGN_BIT);   // denormals
    push_op(INF_POS, ONE, '0, ONE, ONE, ONE);                         // inf * 0
    push_op(INF_POS, ONE, ONE, ONE, INF_POS ^ SIGN_BIT, ONE);         // inf - inf
    push_op(MAX_FIN, MAX_FIN, MAX_FIN, MAX_FIN, MAX_FIN, ONE);        // overflow
    push_op(MIN_NORM, MIN_NORM, 32'h3F00_0000, ONE, '0, '0);          // tiny
    push_op(ONE, ONE, ONE, ONE, 32'hBF80_0000, 32'hBF80_0000);        // cancel
    push_op(SIGN_BIT, SIGN_BIT, ONE, ONE, SIGN_BIT, SIGN_BIT);        // -0 + -0
    push_op(32'h3F80_0001, ONE, 32'h3F80_0001, 32'h3F7F_FFFF, 32'h3380_0000, ONE);
    push_op(32'h7FC0_1234, ONE, ONE, ONE, ONE, 32'hFF80_0001);        // NaN in
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    directed_set();
    reg_write(REG_COMPLEX_MODE, 32'd1);
    directed_set();
    reg_write(REG_USE_CONSTANT, 32'd1);
    reg_write(REG_CONST_RE, 32'hFFFF_FFFF);
    reg_write(REG_CONST_IM, 32'h0000_0000);
    run_random(100);
    // block fills while the receiver holds off
    hold_cycles = 60;
    run_random(300);
    reg_write(REG_CONST_RE, ONE);
    reg_write(REG_CONST_IM, INF_POS);
    run_random(100);
    reg_write(REG_USE_CONSTANT, 32'd0);
    calm_in  = 1'b1;
    calm_out = 1'b1;
    run_random(300);
    calm_in  = 1'b0;
    calm_out = 1'b0;
    run_random(500);
    reg_write(REG_COMPLEX_MODE, 32'd0);
    run_random(300);
    reg_write(REG_USE_CONSTANT, 32'd1);
    reg_write(REG_CONST_RE, {1'b0, 8'd127, 23'($urandom)});
    run_random(200);
    reg_write(REG_COMPLEX_MODE, 32'd1);
    reg_write(REG_CONST_IM, $urandom);
    run_random(200);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
